// ===== sv/ncsg_pkg.sv =====
// shared constants, tables and types of the ntsc composite sample generator
package ncsg_pkg;

    localparam int unsigned ACTIVE_WIDTH_DEF = 768;

    // raster geometry at four samples per subcarrier cycle
    localparam logic [9:0]  LINE_LAST    = 10'd909;
    localparam logic [9:0]  FRAME_LAST   = 10'd524;
    localparam logic [17:0] FIELD_LAST   = 18'd238874;
    localparam logic [17:0] FIELD_LEAD   = 18'd18342;
    localparam logic [8:0]  HALF_LAST    = 9'd454;
    localparam logic [17:0] VBLANK_END   = 18'd18200;
    localparam logic [17:0] VSYNC_END    = 18'd8190;
    localparam logic [17:0] SERR_START   = 18'd2730;
    localparam logic [17:0] SERR_END     = 18'd5460;

    localparam logic [7:0] CODE_BLANK = 8'd60;
    localparam logic [7:0] CODE_SYNC  = 8'd4;

    // 7.5 ire setup plus blanking, q16
    localparam logic signed [26:0] ACTIVE_OFFSET = 27'sd4653055;

    // rgb weights per subcarrier phase: y-i, y-q, y+i, y+q in q16
    localparam logic signed [16:0] WEIGHT_TAB [4][3] = '{
        '{-17'sd10196, 17'sd29601,  17'sd14956},
        '{ 17'sd3008,  17'sd38127, -17'sd6774},
        '{ 17'sd30744, 17'sd10740, -17'sd7122},
        '{ 17'sd17540, 17'sd2213,   17'sd14608}
    };

    localparam logic [7:0] FALL_TAB [3] = '{8'd58, 8'd41, 8'd17};
    localparam logic [7:0] RISE_TAB [3] = '{8'd6, 8'd23, 8'd47};

    // row 0 full burst, rows 1..5 rising envelope, rows 6..11 falling
    localparam logic [7:0] BURST_TAB [12][4] = '{
        '{8'd45, 8'd83, 8'd75, 8'd37},
        '{8'd59, 8'd62, 8'd61, 8'd58},
        '{8'd57, 8'd65, 8'd63, 8'd55},
        '{8'd54, 8'd69, 8'd66, 8'd51},
        '{8'd50, 8'd75, 8'd70, 8'd45},
        '{8'd47, 8'd80, 8'd73, 8'd40},
        '{8'd46, 8'd82, 8'd74, 8'd38},
        '{8'd48, 8'd78, 8'd72, 8'd42},
        '{8'd51, 8'd74, 8'd69, 8'd46},
        '{8'd55, 8'd68, 8'd65, 8'd52},
        '{8'd57, 8'd65, 8'd63, 8'd55},
        '{8'd59, 8'd61, 8'd61, 8'd59}
    };

    // raster position of one sample
    typedef struct packed {
        logic [9:0]  x;         // sample within line
        logic [9:0]  line;      // line within frame
        logic [17:0] in_field;  // sample within field, offset by field lead
        logic [8:0]  h;         // half-line position, shifted
        logic [1:0]  ph;        // subcarrier phase
    } t_timing;

endpackage

// ===== sv/ntsc_composite_sample_generator.sv =====
// top level of the ntsc composite sample generator
//
// usage: one rgb request in gives one composite code out, four samples per
// subcarrier cycle, 910 samples per line, 525 interlaced lines, and a raster
// position that repeats every four fields (955500 requests).
// input channel: i_valid / o_ready with i_red, i_green, i_blue. the pixel is
// only looked at during active video; outside it the request still advances
// the raster and yields a sync, blanking or burst code.
// output channel: o_valid / i_ready with the composite code, a pixel_used
// flag and the bitmap column and row of the pixel taken.
// pipeline: an accepted request passes the input register, then the result
// register, where its result is offered. throughput: one request per clock
// while the output is not stalled, set by the combinational decode and three
// small multipliers between the two registers.
// reset: the raster restarts at sample 0 of line 0 of frame 0, both
// pipeline registers empty.
// stall: while i_ready is low the result holds; one more request is taken
// into the input register, after which o_ready drops until the result moves.
module ntsc_composite_sample_generator
    import ncsg_pkg::*;
#(
    parameter int unsigned ACTIVE_WIDTH = ACTIVE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_composite_sample,
    output logic       o_pixel_used,
    output logic [9:0] o_pixel_column,
    output logic [9:0] o_pixel_row
);

    localparam logic [9:0] ACT_W = 10'(ACTIVE_WIDTH);

    // raster counters, one step per accepted request
    t_timing r_pos, n_pos;

    // input register
    logic       r_s1_valid;
    t_timing    r_s1_pos;
    logic [7:0] r_s1_red, r_s1_green, r_s1_blue;

    // result register
    logic       r_out_valid;
    logic [7:0] r_code;
    logic       r_used;
    logic [9:0] r_col, r_row;

    logic       in_fire, out_free, s1_move;
    logic [7:0] n_code;
    logic       n_used;
    logic [9:0] n_col, n_row;

    assign out_free = !r_out_valid || i_ready;
    assign s1_move  = r_s1_valid && out_free;
    assign o_ready  = !r_s1_valid || out_free;
    assign in_fire  = i_valid && o_ready;

    // all raster periods divide the four-field cycle, so each counter
    // wraps on its own and they stay aligned
    always_comb begin
        n_pos    = r_pos;
        n_pos.ph = r_pos.ph + 2'd1;
        if (r_pos.x == LINE_LAST) begin
            n_pos.x    = '0;
            n_pos.line = (r_pos.line == FRAME_LAST) ? '0 : r_pos.line + 10'd1;
        end else begin
            n_pos.x = r_pos.x + 10'd1;
        end
        n_pos.in_field = (r_pos.in_field == FIELD_LAST) ? '0 : r_pos.in_field + 18'd1;
        n_pos.h        = (r_pos.h == HALF_LAST) ? '0 : r_pos.h + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos.x        <= '0;
            r_pos.line     <= '0;
            r_pos.in_field <= FIELD_LEAD;
            r_pos.h        <= '0;
            r_pos.ph       <= '0;
        end else if (in_fire) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pos   <= r_pos;
            r_s1_red   <= i_red;
            r_s1_green <= i_green;
            r_s1_blue  <= i_blue;
        end
    end

    // decode and pixel mix between the two registers
    always_comb begin
        logic [9:0]         x;
        logic [8:0]         h;
        logic [1:0]         ph;
        logic [17:0]        fld;
        logic [9:0]         dx;
        logic [9:0]         lsub;
        logic [8:0]         dh;
        logic [3:0]         brow;
        logic [7:0]         line_code;
        logic [7:0]         vs_code;
        logic               vs_done;
        logic signed [25:0] p_r, p_g, p_b;
        logic signed [26:0] acc;

        x    = r_s1_pos.x;
        h    = r_s1_pos.h;
        ph   = r_s1_pos.ph;
        fld  = r_s1_pos.in_field;
        dx   = '0;
        dh   = '0;
        brow = '0;
        lsub = r_s1_pos.line - 10'd262;

        // horizontal blanking interval: front porch, sync, burst
        if (x <= 10'd782 || x >= 10'd900 || (x >= 10'd853 && x <= 10'd857)) begin
            line_code = CODE_BLANK;
        end else if (x >= 10'd786 && x <= 10'd849) begin
            line_code = CODE_SYNC;
        end else if (x >= 10'd863 && x <= 10'd893) begin
            line_code = BURST_TAB[0][ph];
        end else if (x <= 10'd785) begin
            dx        = x - 10'd783;
            line_code = FALL_TAB[dx[1:0]];
        end else if (x <= 10'd852) begin
            dx        = x - 10'd850;
            line_code = RISE_TAB[dx[1:0]];
        end else if (x <= 10'd862) begin
            // rising burst envelope
            dx        = x - 10'd857;
            brow      = dx[3:0];
            line_code = BURST_TAB[brow][ph];
        end else begin
            // falling burst envelope
            dx        = x - 10'd888;
            brow      = dx[3:0];
            line_code = BURST_TAB[brow][ph];
        end

        // vertical sync: equalizing pulses, serration inside the broad pulses
        vs_done = 1'b0;
        vs_code = CODE_BLANK;
        if (fld >= SERR_START && fld < SERR_END) begin
            if (h <= 9'd260 || h >= 9'd331) begin
                vs_code = CODE_SYNC;
                vs_done = 1'b1;
            end else if (h >= 9'd264 && h <= 9'd327) begin
                vs_code = CODE_BLANK;
                vs_done = 1'b1;
            end else if (h <= 9'd263) begin
                dh      = h - 9'd261;
                vs_code = RISE_TAB[dh[1:0]];
                vs_done = 1'b1;
            end
        end
        if (!vs_done) begin
            if (h <= 9'd327 || h >= 9'd364) begin
                vs_code = CODE_BLANK;
            end else if (h >= 9'd331 && h <= 9'd360) begin
                vs_code = CODE_SYNC;
            end else if (h >= 9'd361) begin
                dh      = h - 9'd361;
                vs_code = RISE_TAB[dh[1:0]];
            end else begin
                dh      = h - 9'd328;
                vs_code = FALL_TAB[dh[1:0]];
            end
        end

        // luma plus or minus chroma for this phase
        p_r = WEIGHT_TAB[ph][0] * $signed({1'b0, r_s1_red});
        p_g = WEIGHT_TAB[ph][1] * $signed({1'b0, r_s1_green});
        p_b = WEIGHT_TAB[ph][2] * $signed({1'b0, r_s1_blue});
        acc = ACTIVE_OFFSET + 27'(p_r) + 27'(p_g) + 27'(p_b);

        n_used = 1'b0;
        n_col  = '0;
        n_row  = '0;
        if (fld >= VBLANK_END) begin
            if (x < ACT_W) begin
                n_used = 1'b1;
                n_col  = x;
                if (acc[26]) begin
                    n_code = 8'd0;
                end else if (acc[25:24] != 2'd0) begin
                    n_code = 8'd255;
                end else begin
                    n_code = acc[23:16];
                end
                // odd field lines take odd rows, even field lines even rows
                if (r_s1_pos.line < 10'd245) begin
                    n_row = {r_s1_pos.line[8:0], 1'b1};
                end else if (r_s1_pos.line >= 10'd262) begin
                    n_row = {lsub[8:0], 1'b0};
                end
            end else begin
                n_code = line_code;
            end
        end else if (fld < VSYNC_END) begin
            n_code = vs_code;
        end else begin
            n_code = line_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_code <= n_code;
            r_used <= n_used;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_composite_sample = r_code;
    assign o_pixel_used       = r_used;
    assign o_pixel_column     = r_col;
    assign o_pixel_row        = r_row;

    // a used pixel lies inside the active width and the frame
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixel_used |-> o_pixel_column < ACT_W && o_pixel_row <= 10'd524)
        else $error("pixel position out of range");

    // blanking samples carry no pixel position
    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel_used |-> o_pixel_column == 10'd0 && o_pixel_row == 10'd0)
        else $error("pixel position on a blanking sample");

    // a buffered request is not dropped while the result stalls
    a_hold_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_ready |=> r_s1_valid && r_out_valid)
        else $error("request lost during stall");

    // the raster's subcarrier phase steps by exactly one per accepted request
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_pos.ph == $past(r_pos.ph) + 2'd1)
        else $error("raster phase did not advance");

endmodule

// ===== test/composite_sample_checker.sv =====
// checker that predicts every composite result and compares it with the block
`timescale 1ns / 100ps

module composite_sample_checker #(
    parameter int unsigned ACTIVE_WIDTH = 768
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [7:0] i_composite_sample,
    input  logic       i_pixel_used,
    input  logic [9:0] i_pixel_column,
    input  logic [9:0] i_pixel_row,
    output int         o_errors,
    output int         o_pending,
    output int         o_results,
    output int         o_active,
    output int         o_vertical
);

    localparam int unsigned SAMPLES_PER_LINE   = 910;
    localparam int unsigned HALF_LINE_SAMPLES  = 455;
    localparam int unsigned SAMPLES_PER_FIELD  = 238875;
    localparam int unsigned SAMPLES_PER_FRAME  = 477750;
    localparam int unsigned RASTER_PERIOD      = 955500;
    localparam int unsigned FIELD_OFFSET       = 18342;
    localparam int unsigned ACTIVE_FIELD_START = 18200;
    localparam int unsigned VSYNC_STOP         = 8190;
    localparam int unsigned SERRATION_START    = 2730;
    localparam int unsigned SERRATION_STOP     = 5460;
    localparam int unsigned HALF_LINE_SHIFT    = 313;
    localparam int unsigned LEVEL_BLANK        = 60;
    localparam int unsigned LEVEL_SYNC         = 4;
    localparam int          SETUP_Q16          = 4653055;
    localparam int          MAX_PRINTED        = 20;

    typedef struct packed {
        logic [7:0] code;
        logic       used;
        logic [9:0] col;
        logic [9:0] row;
    } composite_result_t;

    composite_result_t expected_samples[$];
    int unsigned       raster_pos;

    // q16 rgb weights, phases y-i, y-q, y+i, y+q
    function automatic int rgb_weight(input int unsigned phase, input int unsigned chan);
        case (phase * 3 + chan)
            0:       return -10196;
            1:       return 29601;
            2:       return 14956;
            3:       return 3008;
            4:       return 38127;
            5:       return -6774;
            6:       return 30744;
            7:       return 10740;
            8:       return -7122;
            9:       return 17540;
            10:      return 2213;
            default: return 14608;
        endcase
    endfunction

    function automatic int unsigned sync_fall_level(input int unsigned idx);
        case (idx)
            0:       return 58;
            1:       return 41;
            default: return 17;
        endcase
    endfunction

    function automatic int unsigned sync_rise_level(input int unsigned idx);
        case (idx)
            0:       return 6;
            1:       return 23;
            default: return 47;
        endcase
    endfunction

    // burst row 0 is full amplitude, 1..5 rising envelope, 6..11 falling
    function automatic int unsigned burst_level(input int unsigned row, input int unsigned phase);
        logic [31:0] lv;
        case (row)
            0:       lv = {8'd45, 8'd83, 8'd75, 8'd37};
            1:       lv = {8'd59, 8'd62, 8'd61, 8'd58};
            2:       lv = {8'd57, 8'd65, 8'd63, 8'd55};
            3:       lv = {8'd54, 8'd69, 8'd66, 8'd51};
            4:       lv = {8'd50, 8'd75, 8'd70, 8'd45};
            5:       lv = {8'd47, 8'd80, 8'd73, 8'd40};
            6:       lv = {8'd46, 8'd82, 8'd74, 8'd38};
            7:       lv = {8'd48, 8'd78, 8'd72, 8'd42};
            8:       lv = {8'd51, 8'd74, 8'd69, 8'd46};
            9:       lv = {8'd55, 8'd68, 8'd65, 8'd52};
            10:      lv = {8'd57, 8'd65, 8'd63, 8'd55};
            default: lv = {8'd59, 8'd61, 8'd61, 8'd59};
        endcase
        return int'(lv[31 - 8 * phase -: 8]);
    endfunction

    // horizontal blanking interval: front porch, sync with edges, burst
    function automatic int unsigned horizontal_code(input int unsigned pos);
        int unsigned x;
        int unsigned ph;
        x  = pos % SAMPLES_PER_LINE;
        ph = pos % 4;
        if (x <= 782 || x >= 900 || (x >= 853 && x <= 857)) return LEVEL_BLANK;
        if (x >= 786 && x <= 849) return LEVEL_SYNC;
        if (x >= 863 && x <= 893) return burst_level(0, ph);
        if (x <= 785) return sync_fall_level(x - 783);
        if (x <= 852) return sync_rise_level(x - 850);
        if (x <= 862) return burst_level(1 + x - 858, ph);
        return burst_level(6 + (x - 894) % 6, ph);
    endfunction

    // vertical sync region: equalizing pulses around broad serrated pulses
    function automatic int unsigned vertical_code(input int unsigned fpos);
        int unsigned h;
        h = (fpos + HALF_LINE_SHIFT) % HALF_LINE_SAMPLES;
        if (fpos >= SERRATION_START && fpos < SERRATION_STOP) begin
            if (h <= 260 || h >= 331) return LEVEL_SYNC;
            if (h >= 264 && h <= 327) return LEVEL_BLANK;
            if (h <= 263) return sync_rise_level(h - 261);
        end
        if (h <= 327 || h >= 364) return LEVEL_BLANK;
        if (h >= 331 && h <= 360) return LEVEL_SYNC;
        if (h >= 361) return sync_rise_level(h - 361);
        return sync_fall_level(h - 328);
    endfunction

    function automatic composite_result_t predict_sample(input int unsigned pos,
                                                         input logic [7:0] r,
                                                         input logic [7:0] g,
                                                         input logic [7:0] b);
        composite_result_t res;
        int unsigned       fpos;
        int unsigned       x;
        int unsigned       line;
        int                acc;
        res  = '0;
        fpos = (pos + FIELD_OFFSET) % SAMPLES_PER_FIELD;
        x    = pos % SAMPLES_PER_LINE;
        if (fpos >= ACTIVE_FIELD_START && x < ACTIVE_WIDTH) begin
            line = (pos % SAMPLES_PER_FRAME) / SAMPLES_PER_LINE;
            acc  = SETUP_Q16 + rgb_weight(pos % 4, 0) * int'(r)
                             + rgb_weight(pos % 4, 1) * int'(g)
                             + rgb_weight(pos % 4, 2) * int'(b);
            if (acc < 0) res.code = 8'd0;
            else if ((acc >>> 16) > 255) res.code = 8'd255;
            else res.code = 8'(acc >>> 16);
            // odd field lines land on odd rows, even field on even rows
            if (line < 245) res.row = 10'(line * 2 + 1);
            else if (line >= 262) res.row = 10'((line - 262) * 2);
            else res.row = '0;
            res.used = 1'b1;
            res.col  = 10'(x);
        end else if (fpos >= ACTIVE_FIELD_START || fpos >= VSYNC_STOP) begin
            res.code = 8'(horizontal_code(pos));
        end else begin
            res.code = 8'(vertical_code(fpos));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_errors < MAX_PRINTED)
            $display("mismatch at result %0d: %s got %0d expected %0d", o_results, what, got,
                     want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        composite_result_t want;
        if (!i_rst_n) begin
            raster_pos = 0;
            expected_samples.delete();
            o_errors   = 0;
            o_results  = 0;
            o_active   = 0;
            o_vertical = 0;
        end else begin
            // retire first so a request accepted on this edge is never matched here
            if (i_res_valid && i_res_ready) begin
                o_results++;
                if (expected_samples.size() == 0) begin
                    report_mismatch("result with no request pending", 1, 0);
                end else begin
                    want = expected_samples.pop_front();
                    if (i_composite_sample !== want.code)
                        report_mismatch("composite_sample", int'(i_composite_sample),
                                        int'(want.code));
                    if (i_pixel_used !== want.used)
                        report_mismatch("pixel_used", int'(i_pixel_used), int'(want.used));
                    if (i_pixel_column !== want.col)
                        report_mismatch("pixel_column", int'(i_pixel_column), int'(want.col));
                    if (i_pixel_row !== want.row)
                        report_mismatch("pixel_row", int'(i_pixel_row), int'(want.row));
                end
            end
            if (i_req_valid && i_req_ready) begin
                want = predict_sample(raster_pos, i_red, i_green, i_blue);
                expected_samples.push_back(want);
                if (want.used) o_active++;
                if ((raster_pos + FIELD_OFFSET) % SAMPLES_PER_FIELD < VSYNC_STOP) o_vertical++;
                raster_pos = (raster_pos + 1 == RASTER_PERIOD) ? 0 : raster_pos + 1;
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

// ===== test/tb_ntsc_composite_sample_generator.sv =====
// testbench top: drives rgb requests and output stalls and reports the verdict
`timescale 1ns / 100ps

module tb_ntsc_composite_sample_generator;

    localparam int unsigned ACTIVE_W        = ncsg_pkg::ACTIVE_WIDTH_DEF;
    localparam int unsigned DIRECTED_ITEMS  = 24;
    localparam int unsigned RANDOM_ITEMS    = 1750;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned IDLE_LIMIT      = 5000;
    // two-stage pipeline, a few cycles more to catch stray results
    localparam int unsigned DRAIN_CYCLES    = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_red;
    logic [7:0] i_green;
    logic [7:0] i_blue;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_composite_sample;
    logic       o_pixel_used;
    logic [9:0] o_pixel_column;
    logic [9:0] o_pixel_row;

    int          mismatch_count;
    int          pending_count;
    int          result_count;
    int          active_count;
    int          vertical_count;
    int unsigned sent_count   = 0;
    int unsigned idle_cycles  = 0;
    bit          hold_off_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    ntsc_composite_sample_generator #(
        .ACTIVE_WIDTH(ACTIVE_W)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_red              (i_red),
        .i_green            (i_green),
        .i_blue             (i_blue),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_composite_sample (o_composite_sample),
        .o_pixel_used       (o_pixel_used),
        .o_pixel_column     (o_pixel_column),
        .o_pixel_row        (o_pixel_row)
    );

    // the checker sees both channels, predicts each request and compares results
    composite_sample_checker #(
        .ACTIVE_WIDTH(ACTIVE_W)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_ready        (o_ready),
        .i_red              (i_red),
        .i_green            (i_green),
        .i_blue             (i_blue),
        .i_res_valid        (o_valid),
        .i_res_ready        (i_ready),
        .i_composite_sample (o_composite_sample),
        .i_pixel_used       (o_pixel_used),
        .i_pixel_column     (o_pixel_column),
        .i_pixel_row        (o_pixel_row),
        .o_errors           (mismatch_count),
        .o_pending          (pending_count),
        .o_results          (result_count),
        .o_active           (active_count),
        .o_vertical         (vertical_count)
    );

    // sender gap: mostly none or short, now and then long
    function automatic int unsigned sender_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // a channel value, biased toward 0 and 255 so the extremes show up often
    function automatic logic [7:0] random_channel();
        if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one pixel request and hold it until taken, then maybe go idle
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int unsigned gap;
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_count++;
        gap = sender_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // receiver side: random ready runs and stalls, plus one long hold-off on demand
    initial begin
        int unsigned run;
        int unsigned stall;
        int unsigned pick;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                // long hold-off: the block fills and has to push back on requests
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                run  = $urandom_range(1, 12);
                pick = $urandom_range(0, 99);
                if (pick < 40) stall = 0;
                else if (pick < 85) stall = $urandom_range(1, 3);
                else if (pick < 97) stall = $urandom_range(4, 12);
                else stall = $urandom_range(20, 80);
                i_ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                if (stall != 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // watchdog: too long with neither channel moving means the block is stuck
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL ntsc_composite_sample_generator");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned k;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_red   <= 8'h00;
        i_green <= 8'h00;
        i_blue  <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: the raster opens in active video, so each color pattern
        // goes out four times in a row to land on every subcarrier phase
        for (k = 0; k < DIRECTED_ITEMS; k++) begin
            case (k / 4)
                0:       {r, g, b} = {8'h00, 8'h00, 8'h00};  // black, lowest luma
                1:       {r, g, b} = {8'hFF, 8'hFF, 8'hFF};  // white, highest luma
                2:       {r, g, b} = {8'hFF, 8'h00, 8'h00};  // full red
                3:       {r, g, b} = {8'h00, 8'hFF, 8'h00};  // full green
                4:       {r, g, b} = {8'h00, 8'h00, 8'hFF};  // full blue
                default: {r, g, b} = {8'hAA, 8'h55, 8'hAA};  // alternating bits
            endcase
            send_pixel(r, g, b);
        end

        // random pixels with gaps and stalls, long output hold-off half way
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) hold_off_req = 1'b1;
            send_pixel(random_channel(), random_channel(), random_channel());
        end
        i_valid <= 1'b0;

        // drain: every expected result back, then a few cycles for strays
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d samples checked, %0d active-video pixels, %0d in vertical sync",
                 result_count, active_count, vertical_count);
        $display("summary: color patterns on every phase, first lines with horizontal sync and"
                 , " burst, random gaps, stalls and a hold-off");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("PASS ntsc_composite_sample_generator");
        end else begin
            $display("FAIL ntsc_composite_sample_generator");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ncsg_pkg.sv
sv/ntsc_composite_sample_generator.sv
test/composite_sample_checker.sv
test/tb_ntsc_composite_sample_generator.sv
